// ===== rtl/ibrc_pkg.sv =====
package ibrc_pkg;

    localparam int CHANNEL_COUNT = 6;

    localparam logic [7:0]  START_BYTE     = 8'h20;
    localparam logic [15:0] CHECKSUM_INIT  = 16'hFFDF;
    localparam logic [4:0]  CHECKSUM_BYTES = 5'd29;
    localparam logic [4:0]  LAST_POS       = 5'd30;
    localparam logic [4:0]  FIRST_CH_POS   = 5'd2;

    localparam logic [15:0] THROTTLE_CAP   = 16'd1800;
    localparam logic [16:0] STICK_CENTER   = 17'd1500;
    localparam logic [16:0] POT_OFFSET     = 17'd1000;

    // floor(x / 125) == (x * RECIP_125) >> RECIP_SHIFT for every x below 2**24.
    localparam logic [24:0] RECIP_125      = 25'd17179870;
    localparam int          RECIP_SHIFT    = 31;

    typedef enum logic [2:0] {
        REG_MODE            = 3'd0,
        REG_MAX_ROLL_RATE   = 3'd1,
        REG_MAX_PITCH_RATE  = 3'd2,
        REG_MAX_YAW_RATE    = 3'd3,
        REG_MAX_ROLL_ANGLE  = 3'd4,
        REG_MAX_PITCH_ANGLE = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic s1_load;
        logic s2_load;
        logic s3_load;
    } pipe_ctl_t;

endpackage

// ===== rtl/ibrc_if.sv =====
interface ibrc_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface ibrc_stick_if;
    logic               valid;
    logic               ready;
    logic [10:0]        throttle;
    logic signed [17:0] roll;
    logic signed [17:0] pitch;
    logic signed [17:0] yaw;
    logic signed [16:0] left_pot;
    logic signed [16:0] right_pot;

    modport source (output valid, output throttle, output roll, output pitch, output yaw,
                    output left_pot, output right_pot, input ready);
    modport sink (input valid, input throttle, input roll, input pitch, input yaw,
                  input left_pot, input right_pot, output ready);
endinterface

// ===== rtl/ibrc_axis_scale.sv =====
module ibrc_axis_scale (
    input  logic                clk,
    input  ibrc_pkg::pipe_ctl_t ctl,
    input  logic [15:0]         chan,
    input  logic [9:0]          max_val,
    output logic signed [17:0]  axis
);

    logic [16:0] diff;
    logic [15:0] mag;
    logic [48:0] recip_prod;

    logic        sign1_reg;
    logic [25:0] prod_reg;
    logic        sign2_reg;
    logic [16:0] quot_reg;
    logic [17:0] axis_reg;

    always_comb
    begin
        diff       = {1'b0, chan} - ibrc_pkg::STICK_CENTER;
        mag        = diff[16] ? 16'(~diff + 17'd1) : diff[15:0];
        recip_prod = {1'b0, prod_reg[25:2]} * ibrc_pkg::RECIP_125;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.s1_load)
        begin
            sign1_reg <= diff[16];
            prod_reg  <= mag * max_val;
        end
        if (ctl.s2_load)
        begin
            sign2_reg <= sign1_reg;
            quot_reg  <= recip_prod[ibrc_pkg::RECIP_SHIFT +: 17];
        end
        if (ctl.s3_load)
        begin
            axis_reg <= sign2_reg ? (18'd0 - {1'b0, quot_reg}) : {1'b0, quot_reg};
        end
    end

    assign axis = $signed(axis_reg);

endmodule

// ===== rtl/ibus_rc_frame_decoder_top.sv =====
// Channel  Direction  Carries
// rx       in         rx_byte, one received serial byte per word
// stick    out        throttle, roll, pitch, yaw, left_pot, right_pot
// apb      in/out     mode and the five stick scale registers
//
// One byte is taken every cycle while rx.ready is high; frame parsing and checksum
// update happen at acceptance. A good frame gives one word through a three-stage
// pipeline set by the axis scaling multipliers (product, reciprocal divide, sign).
// Reset clears the parser to hunting and the configuration registers to zero.
// A stalled output backs up the pipeline and only then holds rx.ready low.
module ibus_rc_frame_decoder_top (
    input  logic                clk,
    input  logic                rst_n,
    ibrc_rx_if.sink             rx,
    ibrc_stick_if.source        stick,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic       mode_reg;
    logic [9:0] max_roll_rate_reg;
    logic [9:0] max_pitch_rate_reg;
    logic [9:0] max_yaw_rate_reg;
    logic [9:0] max_roll_angle_reg;
    logic [9:0] max_pitch_angle_reg;

    logic        in_frame_reg,  in_frame_next;
    logic [4:0]  pos_reg,       pos_next;
    logic [15:0] csum_reg,      csum_next;
    logic [7:0]  low_hold_reg,  low_hold_next;
    logic [7:0]  rx_low_reg,    rx_low_next;
    logic [15:0] chan_reg [ibrc_pkg::CHANNEL_COUNT];

    logic        s1_valid_reg, s1_valid_next;
    logic        s2_valid_reg, s2_valid_next;
    logic        out_valid_reg, out_valid_next;
    logic        s1_ready, s2_ready, s3_ready;
    logic        accept, launch, cfg_write;
    logic [4:0]  ch_pos;
    logic [3:0]  ch_idx;
    logic [9:0]  roll_max, pitch_max;
    ibrc_pkg::cfg_reg_t  cfg_idx;
    ibrc_pkg::pipe_ctl_t ctl;

    logic [10:0] thr1_reg,   thr2_reg,   thr3_reg;
    logic [16:0] lpot1_reg,  lpot2_reg,  lpot3_reg;
    logic [16:0] rpot1_reg,  rpot2_reg,  rpot3_reg;

    assign pready    = 1'b1;
    assign cfg_idx   = ibrc_pkg::cfg_reg_t'(paddr[4:2]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg            <= 1'b0;
            max_roll_rate_reg   <= 10'd0;
            max_pitch_rate_reg  <= 10'd0;
            max_yaw_rate_reg    <= 10'd0;
            max_roll_angle_reg  <= 10'd0;
            max_pitch_angle_reg <= 10'd0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                ibrc_pkg::REG_MODE:            mode_reg            <= pwdata[0];
                ibrc_pkg::REG_MAX_ROLL_RATE:   max_roll_rate_reg   <= pwdata[9:0];
                ibrc_pkg::REG_MAX_PITCH_RATE:  max_pitch_rate_reg  <= pwdata[9:0];
                ibrc_pkg::REG_MAX_YAW_RATE:    max_yaw_rate_reg    <= pwdata[9:0];
                ibrc_pkg::REG_MAX_ROLL_ANGLE:  max_roll_angle_reg  <= pwdata[9:0];
                ibrc_pkg::REG_MAX_PITCH_ANGLE: max_pitch_angle_reg <= pwdata[9:0];
                default:                       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            ibrc_pkg::REG_MODE:            prdata = {31'd0, mode_reg};
            ibrc_pkg::REG_MAX_ROLL_RATE:   prdata = {22'd0, max_roll_rate_reg};
            ibrc_pkg::REG_MAX_PITCH_RATE:  prdata = {22'd0, max_pitch_rate_reg};
            ibrc_pkg::REG_MAX_YAW_RATE:    prdata = {22'd0, max_yaw_rate_reg};
            ibrc_pkg::REG_MAX_ROLL_ANGLE:  prdata = {22'd0, max_roll_angle_reg};
            ibrc_pkg::REG_MAX_PITCH_ANGLE: prdata = {22'd0, max_pitch_angle_reg};
            default:                       prdata = 32'd0;
        endcase
    end

    assign s3_ready = !out_valid_reg || stick.ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign rx.ready = s1_ready;
    assign accept   = rx.valid && s1_ready;

    assign ch_pos = pos_reg - ibrc_pkg::FIRST_CH_POS;
    assign ch_idx = ch_pos[4:1];

    always_comb
    begin
        in_frame_next = in_frame_reg;
        pos_next      = pos_reg;
        csum_next     = csum_reg;
        low_hold_next = low_hold_reg;
        rx_low_next   = rx_low_reg;
        launch        = 1'b0;
        if (accept)
        begin
            if (!in_frame_reg)
            begin
                if (rx.rx_byte == ibrc_pkg::START_BYTE)
                begin
                    in_frame_next = 1'b1;
                    pos_next      = 5'd0;
                    csum_next     = ibrc_pkg::CHECKSUM_INIT;
                end
            end
            else
            begin
                if (pos_reg < ibrc_pkg::CHECKSUM_BYTES)
                begin
                    csum_next = csum_reg - {8'd0, rx.rx_byte};
                    if (pos_reg[0])
                    begin
                        low_hold_next = rx.rx_byte;
                    end
                end
                if (pos_reg == ibrc_pkg::CHECKSUM_BYTES)
                begin
                    rx_low_next = rx.rx_byte;
                end
                if (pos_reg == ibrc_pkg::LAST_POS)
                begin
                    in_frame_next = 1'b0;
                    pos_next      = 5'd0;
                    launch        = ({rx.rx_byte, rx_low_reg} == csum_reg);
                end
                else
                begin
                    pos_next = pos_reg + 5'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            pos_reg      <= 5'd0;
            csum_reg     <= ibrc_pkg::CHECKSUM_INIT;
            low_hold_reg <= 8'd0;
            rx_low_reg   <= 8'd0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            pos_reg      <= pos_next;
            csum_reg     <= csum_next;
            low_hold_reg <= low_hold_next;
            rx_low_reg   <= rx_low_next;
        end
    end

    // Channels land on the high byte, at even body positions two through twelve.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ibrc_pkg::CHANNEL_COUNT; i++)
        begin
            if (accept && in_frame_reg && !pos_reg[0] && pos_reg >= ibrc_pkg::FIRST_CH_POS
                && pos_reg < ibrc_pkg::CHECKSUM_BYTES && ch_idx == 4'(i))
            begin
                chan_reg[i] <= {rx.rx_byte, low_hold_reg};
            end
        end
    end

    always_comb
    begin
        s1_valid_next  = s1_ready ? launch : s1_valid_reg;
        s2_valid_next  = s2_ready ? s1_valid_reg : s2_valid_reg;
        out_valid_next = s3_ready ? s2_valid_reg : out_valid_reg;
        ctl.s1_load    = launch;
        ctl.s2_load    = s1_valid_reg && s2_ready;
        ctl.s3_load    = s2_valid_reg && s3_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.s1_load)
        begin
            thr1_reg  <= (chan_reg[2] > ibrc_pkg::THROTTLE_CAP) ?
                         ibrc_pkg::THROTTLE_CAP[10:0] : chan_reg[2][10:0];
            lpot1_reg <= {1'b0, chan_reg[4]} - ibrc_pkg::POT_OFFSET;
            rpot1_reg <= {1'b0, chan_reg[5]} - ibrc_pkg::POT_OFFSET;
        end
        if (ctl.s2_load)
        begin
            thr2_reg  <= thr1_reg;
            lpot2_reg <= lpot1_reg;
            rpot2_reg <= rpot1_reg;
        end
        if (ctl.s3_load)
        begin
            thr3_reg  <= thr2_reg;
            lpot3_reg <= lpot2_reg;
            rpot3_reg <= rpot2_reg;
        end
    end

    assign roll_max  = mode_reg ? max_roll_angle_reg : max_roll_rate_reg;
    assign pitch_max = mode_reg ? max_pitch_angle_reg : max_pitch_rate_reg;

    ibrc_axis_scale u_roll (
        .clk     (clk),
        .ctl     (ctl),
        .chan    (chan_reg[0]),
        .max_val (roll_max),
        .axis    (stick.roll)
    );

    ibrc_axis_scale u_pitch (
        .clk     (clk),
        .ctl     (ctl),
        .chan    (chan_reg[1]),
        .max_val (pitch_max),
        .axis    (stick.pitch)
    );

    ibrc_axis_scale u_yaw (
        .clk     (clk),
        .ctl     (ctl),
        .chan    (chan_reg[3]),
        .max_val (max_yaw_rate_reg),
        .axis    (stick.yaw)
    );

    assign stick.valid     = out_valid_reg;
    assign stick.throttle  = thr3_reg;
    assign stick.left_pot  = $signed(lpot3_reg);
    assign stick.right_pot = $signed(rpot3_reg);

endmodule
